### src/cmli_pkg.sv
// ----------------------------------------------------------------------------
// cmli_pkg: shared types and constants of the color map lookup interpolator
// Field widths, request codes, stream widths and position helper functions.
// ----------------------------------------------------------------------------
package cmli_pkg;

	localparam int DEF_TABLE_ENTRIES = 256;

	localparam int POS_W  = 24;  // signed q8.16 position
	localparam int IDX_W  = 10;  // table index field
	localparam int COL_W  = 16;  // one color channel
	localparam int ONE_W  = 17;  // q1.16 scalar in [0, 1.0]
	localparam int FRAC_W = 16;

	localparam logic [ONE_W-1:0] ONE_Q16 = ONE_W'(1) << FRAC_W;

	localparam int IN_TDATA_W  = 168;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 3 * COL_W;
	localparam int OUT_TUSER_W = 2;

	typedef enum logic [1:0] {
		REQ_SAMPLE_CLAMP = 2'd0,
		REQ_SAMPLE_WRAP  = 2'd1,
		REQ_SPAN_INDEX   = 2'd2,
		REQ_SPAN_POS     = 2'd3
	} req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef logic [2:0][COL_W-1:0] rgb_t;

	function automatic logic [ONE_W-1:0] clamp01(input logic signed [POS_W-1:0] p);
		logic [ONE_W-1:0] r;
		if (p < 0) begin
			r = '0;
		end else if (p > $signed(POS_W'(ONE_Q16))) begin
			r = ONE_Q16;
		end else begin
			r = p[ONE_W-1:0];
		end
		return r;
	endfunction

	// negative exact integers land on 1.0
	function automatic logic [ONE_W-1:0] wrap01(input logic signed [POS_W-1:0] p);
		logic [ONE_W-1:0] r;
		if (p[POS_W-1] && (p[FRAC_W-1:0] == '0)) begin
			r = ONE_Q16;
		end else begin
			r = {1'b0, p[FRAC_W-1:0]};
		end
		return r;
	endfunction

endpackage

### src/cmli_div.sv
// ----------------------------------------------------------------------------
// cmli_div: three-lane bit-serial floor divider
// Divides three signed channel deltas by one small unsigned divisor, one
// quotient bit per cycle, and returns floor quotient and non-negative remainder.
// ----------------------------------------------------------------------------
module cmli_div #(
	parameter int NW = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [NW-1:0]                       divisor,
	input  logic [2:0][cmli_pkg::COL_W:0]       dividend,
	output logic [2:0][cmli_pkg::COL_W:0]       quotient,
	output logic [2:0][NW-1:0]                  remainder,
	output cmli_pkg::div_stat_t                 stat
);
	import cmli_pkg::*;

	localparam int CW = $clog2(COL_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [NW-1:0]     div_q;
	logic [2:0]        neg_q;
	logic [2:0][COL_W-1:0] mag_q;
	logic [2:0][NW-1:0]    rem_q;

	logic [2:0][COL_W:0]   neg_in;
	logic [2:0][COL_W-1:0] mag_in;
	logic [2:0][NW:0]      trial;
	logic [2:0][NW:0]      diff;
	logic [2:0]            fits;
	logic [2:0][COL_W:0]   qm;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			neg_in[l] = -dividend[l];
			mag_in[l] = dividend[l][COL_W] ? neg_in[l][COL_W-1:0] : dividend[l][COL_W-1:0];
			trial[l]  = {rem_q[l], mag_q[l][COL_W-1]};
			diff[l]   = trial[l] - {1'b0, div_q};
			fits[l]   = trial[l] >= {1'b0, div_q};
			qm[l]     = {1'b0, mag_q[l]} + (COL_W+1)'(rem_q[l] != '0);
			// round toward minus infinity for negative deltas
			quotient[l]  = neg_q[l] ? -qm[l] : {1'b0, mag_q[l]};
			remainder[l] = (neg_q[l] && (rem_q[l] != '0)) ? div_q - rem_q[l] : rem_q[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(COL_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// quotient bits shift in where dividend bits shift out
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			for (int l = 0; l < 3; l++) begin
				neg_q[l] <= dividend[l][COL_W];
				mag_q[l] <= mag_in[l];
				rem_q[l] <= '0;
			end
		end else if (busy_q) begin
			for (int l = 0; l < 3; l++) begin
				mag_q[l] <= {mag_q[l][COL_W-2:0], fits[l]};
				rem_q[l] <= fits[l] ? diff[l][NW-1:0] : trial[l][NW-1:0];
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

### src/color_map_lut_interpolator_core.sv
// ----------------------------------------------------------------------------
// color_map_lut_interpolator_core: interpolated scalar-to-rgb color map
// Table of rgb entries in one synchronous memory; sample reads blend two
// neighboring entries, span writes fill a rounded linear ramp.
// ----------------------------------------------------------------------------
// usage:
//  s_axis carries requests: tuser is the request kind, tdata the positions,
//  indices and two end colors. m_axis returns exactly one item per request:
//  the blended color for samples, done/error flags for spans.
//  after reset the block sweeps the table to zero, one entry per cycle, and
//  holds s_axis_tready low meanwhile. one request is worked on at a time.
//  a sample passes through multiply, memory read, blend products, sum and
//  output load before its result shows on m_axis. a span needs one pass of
//  the 16-step serial divider for its per-entry slope, then one memory write
//  per entry, for n+1 entries; span by position first rounds its positions
//  to indices. out-of-range spans skip the divider and the writes. the next
//  item is taken once the result of the last has moved into the output
//  register. the memory write port sets the span rate.
//  a finished result waits in the output register while the receiver stalls;
//  a new item is taken meanwhile and its result waits until the register frees.
// ----------------------------------------------------------------------------
module color_map_lut_interpolator_core #(
	parameter int TABLE_ENTRIES = cmli_pkg::DEF_TABLE_ENTRIES
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// position_a, position_b, index_a, index_b, color_a_red, color_a_green,
	// color_a_blue, color_b_red, color_b_green, color_b_blue, zero pad
	input  logic [cmli_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// req_type
	input  logic [cmli_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// out_red, out_green, out_blue
	output logic [cmli_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	// span_done, span_error
	output logic [cmli_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);
	import cmli_pkg::*;

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [AW-1:0] MAX_IDX = AW'(TABLE_ENTRIES - 1);
	localparam int PW = ONE_W + AW;
	localparam logic [PW:0] HALF_RND = (PW+1)'(1) << (FRAC_W - 1);

	typedef enum logic [10:0] {
		ST_CLEAR    = 11'b000_0000_0001,
		ST_IDLE     = 11'b000_0000_0010,
		ST_S_MUL    = 11'b000_0000_0100,
		ST_S_RD     = 11'b000_0000_1000,
		ST_S_MUL2   = 11'b000_0001_0000,
		ST_S_SUM    = 11'b000_0010_0000,
		ST_P_MUL    = 11'b000_0100_0000,
		ST_P_RND    = 11'b000_1000_0000,
		ST_SPAN_CHK = 11'b001_0000_0000,
		ST_DIV      = 11'b010_0000_0000,
		ST_WRITE    = 11'b100_0000_0000
	} state_t;

	// done state shares the idle exit logic through out_free
	localparam state_t ST_DONE_UNUSED = ST_IDLE;

	state_t state_q;
	logic   done_q;
	logic [AW-1:0] clr_q;
	logic   out_valid_q;

	// input fields
	req_t                    in_type;
	logic signed [POS_W-1:0] pos_a;
	logic signed [POS_W-1:0] pos_b;
	logic [IDX_W-1:0]        idx_a;
	logic [IDX_W-1:0]        idx_b;
	rgb_t                    col_a;
	rgb_t                    col_b;
	logic                    swap;

	assign in_type = req_t'(s_axis_tuser);
	assign pos_a   = s_axis_tdata[23:0];
	assign pos_b   = s_axis_tdata[47:24];
	assign idx_a   = s_axis_tdata[57:48];
	assign idx_b   = s_axis_tdata[67:58];
	assign col_a   = s_axis_tdata[115:68];
	assign col_b   = s_axis_tdata[163:116];
	assign swap    = (in_type == REQ_SPAN_INDEX) ? (idx_b < idx_a) : (pos_b < pos_a);

	// request and datapath registers
	logic [ONE_W-1:0]      s_lo_q;
	logic [ONE_W-1:0]      s_hi_q;
	logic [IDX_W-1:0]      ilo_q;
	logic [IDX_W-1:0]      ihi_q;
	rgb_t                  clo_q;
	rgb_t                  chi_q;
	logic [PW-1:0]         prod_lo_q;
	logic [PW-1:0]         prod_hi_q;
	logic [FRAC_W-1:0]     a_q;
	logic [2:0][2*COL_W-1:0] mhi_q;
	logic [2:0][2*COL_W:0]   mlo_q;
	rgb_t                  res_q;
	logic                  flag_done_q;
	logic                  flag_err_q;
	logic [AW-1:0]         n_q;
	logic [AW-1:0]         addr_q;
	logic [AW-1:0]         cnt_q;
	rgb_t                  q_q;
	logic [2:0][AW-1:0]    r_q;
	logic [2:0][COL_W:0]   dq_q;
	logic [2:0][AW-1:0]    dr_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic [OUT_TUSER_W-1:0] out_user_q;

	// table memory
	rgb_t          mem [TABLE_ENTRIES];
	rgb_t          rd_lo_q;
	rgb_t          rd_hi_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	rgb_t          mem_wdata;
	logic [AW-1:0] rd_lo_addr;
	logic [AW-1:0] rd_hi_addr;

	// divider
	logic                div_start;
	logic [2:0][COL_W:0] div_delta;
	logic [2:0][COL_W:0] div_quo;
	logic [2:0][AW-1:0]  div_rem;
	div_stat_t           div_stat;

	logic acc;
	logic out_free;
	logic span_err;
	logic [AW-1:0] span_n;

	logic [AW:0]   samp_lo_w;
	logic [AW+1:0] samp_hi_w;
	logic [PW:0]   rnd_lo;
	logic [PW:0]   rnd_hi;
	logic [ONE_W-1:0] wa;
	logic [2:0][2*COL_W+1:0] blend_sum;
	logic [2:0][AW:0]        r_sum;
	logic [2:0]              step_ge;
	logic [2:0][AW-1:0]      r_nxt;
	logic [2:0][COL_W+1:0]   q_sum;

	assign s_axis_tready = (state_q == ST_IDLE) && !done_q;
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign span_err      = {1'b0, ihi_q} >= (IDX_W+1)'(TABLE_ENTRIES);
	assign span_n        = AW'(ihi_q - ilo_q);
	assign div_start     = (state_q == ST_SPAN_CHK) && !span_err;

	always_comb begin
		samp_lo_w  = prod_lo_q[PW-1:FRAC_W];
		samp_hi_w  = {1'b0, samp_lo_w} + 1'b1;
		rd_lo_addr = (samp_lo_w > {1'b0, MAX_IDX}) ? MAX_IDX : samp_lo_w[AW-1:0];
		// upper neighbor saturates at the last entry
		rd_hi_addr = (samp_hi_w > {2'b00, MAX_IDX}) ? MAX_IDX : samp_hi_w[AW-1:0];
		rnd_lo     = {1'b0, prod_lo_q} + HALF_RND;
		rnd_hi     = {1'b0, prod_hi_q} + HALF_RND;
		wa         = ONE_Q16 - {1'b0, a_q};
		for (int c = 0; c < 3; c++) begin
			blend_sum[c] = (2*COL_W+2)'(mhi_q[c]) + (2*COL_W+2)'(mlo_q[c])
			             + (2*COL_W+2)'(HALF_RND);
			div_delta[c] = {1'b0, chi_q[c]} - {1'b0, clo_q[c]};
			r_sum[c]     = {1'b0, r_q[c]} + {1'b0, dr_q[c]};
			step_ge[c]   = r_sum[c] >= {1'b0, n_q};
			r_nxt[c]     = step_ge[c] ? AW'(r_sum[c] - {1'b0, n_q}) : r_sum[c][AW-1:0];
			q_sum[c]     = {2'b00, q_q[c]} + {dq_q[c][COL_W], dq_q[c]}
			             + (COL_W+2)'(step_ge[c]);
		end
		mem_we    = (state_q == ST_CLEAR) || (state_q == ST_WRITE);
		mem_waddr = (state_q == ST_CLEAR) ? clr_q : addr_q;
		mem_wdata = (state_q == ST_CLEAR) ? rgb_t'('0) : q_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_lo_q <= mem[rd_lo_addr];
		rd_hi_q <= mem[rd_hi_addr];
	end

	cmli_div #(
		.NW(AW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (span_n),
		.dividend (div_delta),
		.quotient (div_quo),
		.remainder(div_rem),
		.stat     (div_stat)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			done_q      <= 1'b0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (done_q && out_free) begin
				out_valid_q <= 1'b1;
				done_q      <= 1'b0;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == MAX_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc) begin
						case (in_type)
							REQ_SAMPLE_CLAMP, REQ_SAMPLE_WRAP: state_q <= ST_S_MUL;
							REQ_SPAN_INDEX:                    state_q <= ST_SPAN_CHK;
							REQ_SPAN_POS:                      state_q <= ST_P_MUL;
							default:                           state_q <= ST_IDLE;
						endcase
					end
				end
				ST_S_MUL:  state_q <= ST_S_RD;
				ST_S_RD:   state_q <= ST_S_MUL2;
				ST_S_MUL2: state_q <= ST_S_SUM;
				ST_S_SUM: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				ST_P_MUL:  state_q <= ST_P_RND;
				ST_P_RND:  state_q <= ST_SPAN_CHK;
				ST_SPAN_CHK: begin
					if (span_err) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (cnt_q == '0) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (done_q && out_free) begin
			out_data_q <= res_q;
			out_user_q <= {flag_err_q, flag_done_q};
		end
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (in_type == REQ_SAMPLE_WRAP) begin
						s_lo_q <= wrap01(pos_a);
					end else if (in_type == REQ_SAMPLE_CLAMP) begin
						s_lo_q <= clamp01(pos_a);
					end else begin
						s_lo_q <= clamp01(swap ? pos_b : pos_a);
					end
					s_hi_q <= clamp01(swap ? pos_a : pos_b);
					ilo_q  <= swap ? idx_b : idx_a;
					ihi_q  <= swap ? idx_a : idx_b;
					clo_q  <= swap ? col_b : col_a;
					chi_q  <= swap ? col_a : col_b;
				end
			end
			ST_S_MUL: begin
				prod_lo_q <= PW'(s_lo_q) * PW'(MAX_IDX);
			end
			ST_S_RD: begin
				a_q <= prod_lo_q[FRAC_W-1:0];
			end
			ST_S_MUL2: begin
				for (int c = 0; c < 3; c++) begin
					mhi_q[c] <= (2*COL_W)'(rd_hi_q[c]) * (2*COL_W)'(a_q);
					mlo_q[c] <= (2*COL_W+1)'(rd_lo_q[c]) * (2*COL_W+1)'(wa);
				end
			end
			ST_S_SUM: begin
				for (int c = 0; c < 3; c++) begin
					res_q[c] <= blend_sum[c][2*COL_W-1:COL_W];
				end
				flag_done_q <= 1'b0;
				flag_err_q  <= 1'b0;
			end
			ST_P_MUL: begin
				prod_lo_q <= PW'(s_lo_q) * PW'(MAX_IDX);
				prod_hi_q <= PW'(s_hi_q) * PW'(MAX_IDX);
			end
			ST_P_RND: begin
				ilo_q <= IDX_W'(rnd_lo[FRAC_W+AW-1:FRAC_W]);
				ihi_q <= IDX_W'(rnd_hi[FRAC_W+AW-1:FRAC_W]);
			end
			ST_SPAN_CHK: begin
				res_q       <= '0;
				flag_done_q <= !span_err;
				flag_err_q  <= span_err;
				n_q         <= span_n;
				cnt_q       <= span_n;
				addr_q      <= ilo_q[AW-1:0];
				q_q         <= clo_q;
				for (int c = 0; c < 3; c++) begin
					r_q[c] <= span_n >> 1;
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					dq_q <= div_quo;
					dr_q <= div_rem;
				end
			end
			ST_WRITE: begin
				// ramp step: quotient and remainder advance by slope, carry on overflow
				addr_q <= addr_q + 1'b1;
				cnt_q  <= cnt_q - 1'b1;
				for (int c = 0; c < 3; c++) begin
					r_q[c] <= r_nxt[c];
					q_q[c] <= q_sum[c][COL_W-1:0];
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	// checks
	a_wr_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (mem_waddr <= MAX_IDX))
		else $error("table write address beyond last entry");

	a_ramp_rem: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_WRITE) && (n_q != '0)) |->
		((r_q[0] < n_q) && (r_q[1] < n_q) && (r_q[2] < n_q)))
		else $error("ramp remainder not below span length");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_DIV))
		else $error("divider finished outside its wait state");

	a_idle_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !div_stat.busy)
		else $error("divider busy while idle");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(done_q))
		else $error("result shown without a finished item");

	a_no_accept_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (state_q == ST_DONE_UNUSED)) |-> !s_axis_tready)
		else $error("item taken while a result waits for the output register");

endmodule

### test/color_map_lut_interpolator_core_test.sv
// ----------------------------------------------------------------------------
// color_map_lut_interpolator_core_test: self-checking bench for the color map
// Drives sample and span requests over the input stream and predicts each
// result from a private copy of the color table. Both stream sides idle at
// random, and one long output stall makes the block back up its input.
// ----------------------------------------------------------------------------
module color_map_lut_interpolator_core_test;

	import cmli_pkg::*;

	localparam int TABLE_ENTRIES = DEF_TABLE_ENTRIES;
	localparam int RANDOM_ITEMS  = 1625;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_CYCLES  = 40;
	localparam int MAX_PRINTED   = 40;

	typedef struct {
		req_t                    kind;
		logic signed [POS_W-1:0] pos_a;
		logic signed [POS_W-1:0] pos_b;
		logic [IDX_W-1:0]        idx_a;
		logic [IDX_W-1:0]        idx_b;
		rgb_t                    col_a;
		rgb_t                    col_b;
	} lut_request_t;

	typedef struct packed {
		logic [COL_W-1:0] red;
		logic [COL_W-1:0] green;
		logic [COL_W-1:0] blue;
		logic             span_done;
		logic             span_error;
	} color_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	// position_a, position_b, index_a, index_b, color_a_red, color_a_green,
	// color_a_blue, color_b_red, color_b_green, color_b_blue, zero pad
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	// req_type
	logic [IN_TUSER_W-1:0]  s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	// out_red, out_green, out_blue
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	// span_done, span_error
	logic [OUT_TUSER_W-1:0] m_axis_tuser;

	rgb_t          lut_model [TABLE_ENTRIES];
	color_result_t expected_colors [$];
	int            error_count;
	bit            idle_on;
	bit            hold_request;
	int            hold_left;

	color_map_lut_interpolator_core #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic [ONE_W-1:0] clamp_unit(input logic signed [POS_W-1:0] p);
		if (p < 0) begin
			return '0;
		end else if (p > 24'sd65536) begin
			return 17'h10000;
		end
		return p[ONE_W-1:0];
	endfunction

	function automatic logic [ONE_W-1:0] wrap_unit(input logic signed [POS_W-1:0] p);
		// a negative exact integer lands on 1.0, anything else keeps its fraction
		if (p[POS_W-1] && p[FRAC_W-1:0] == '0) begin
			return 17'h10000;
		end
		return {1'b0, p[FRAC_W-1:0]};
	endfunction

	function automatic rgb_t blend_lookup(input logic [ONE_W-1:0] s);
		int unsigned     prod;
		int unsigned     lo;
		int unsigned     hi;
		int unsigned     frac;
		longint unsigned acc;
		rgb_t            col;
		prod = 32'(s) * 32'(TABLE_ENTRIES - 1);
		lo   = prod >> 16;
		frac = prod & 32'hFFFF;
		hi   = lo + 1;
		if (lo > TABLE_ENTRIES - 1) begin
			lo = TABLE_ENTRIES - 1;
		end
		if (hi > TABLE_ENTRIES - 1) begin
			hi = TABLE_ENTRIES - 1;
		end
		for (int c = 0; c < 3; c++) begin
			acc = 64'(lut_model[hi][c]) * 64'(frac)
			    + 64'(lut_model[lo][c]) * 64'(32'h10000 - frac) + 64'd32768;
			col[c] = 16'(acc >> 16);
		end
		return col;
	endfunction

	function automatic void write_ramp(input int unsigned lo, input int unsigned hi,
	                                   input rgb_t clo, input rgb_t chi);
		int unsigned     n;
		longint unsigned v;
		n = hi - lo;
		if (n == 0) begin
			lut_model[lo] = clo;
			return;
		end
		for (int unsigned k = 0; k <= n; k++) begin
			for (int c = 0; c < 3; c++) begin
				v = 64'(clo[c]) * 64'(n - k) + 64'(chi[c]) * 64'(k) + 64'(n / 2);
				lut_model[lo + k][c] = 16'(v / n);
			end
		end
	endfunction

	function automatic color_result_t predict_color_result(input lut_request_t req);
		color_result_t res;
		rgb_t          col;
		rgb_t          clo;
		rgb_t          chi;
		int unsigned   lo;
		int unsigned   hi;
		logic [ONE_W-1:0] sl;
		logic [ONE_W-1:0] sh;
		res = '0;
		case (req.kind)
			REQ_SAMPLE_CLAMP, REQ_SAMPLE_WRAP: begin
				if (req.kind == REQ_SAMPLE_CLAMP) begin
					col = blend_lookup(clamp_unit(req.pos_a));
				end else begin
					col = blend_lookup(wrap_unit(req.pos_a));
				end
				res.red   = col[0];
				res.green = col[1];
				res.blue  = col[2];
				return res;
			end
			REQ_SPAN_INDEX: begin
				if (req.idx_b < req.idx_a) begin
					lo = 32'(req.idx_b); hi = 32'(req.idx_a);
					clo = req.col_b; chi = req.col_a;
				end else begin
					lo = 32'(req.idx_a); hi = 32'(req.idx_b);
					clo = req.col_a; chi = req.col_b;
				end
			end
			default: begin
				if (req.pos_b < req.pos_a) begin
					sl = clamp_unit(req.pos_b); sh = clamp_unit(req.pos_a);
					clo = req.col_b; chi = req.col_a;
				end else begin
					sl = clamp_unit(req.pos_a); sh = clamp_unit(req.pos_b);
					clo = req.col_a; chi = req.col_b;
				end
				lo = (32'(sl) * 32'(TABLE_ENTRIES - 1) + 32'd32768) >> 16;
				hi = (32'(sh) * 32'(TABLE_ENTRIES - 1) + 32'd32768) >> 16;
			end
		endcase
		if (hi >= TABLE_ENTRIES || lo > hi) begin
			res.span_error = 1'b1;
		end else begin
			write_ramp(lo, hi, clo, chi);
			res.span_done = 1'b1;
		end
		return res;
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	function automatic rgb_t rgb(input logic [COL_W-1:0] r, input logic [COL_W-1:0] g,
	                             input logic [COL_W-1:0] b);
		return {b, g, r};
	endfunction

	function automatic lut_request_t sample_req(input req_t kind,
	                                            input logic signed [POS_W-1:0] pos);
		lut_request_t req;
		req.kind  = kind;
		req.pos_a = pos;
		req.pos_b = 24'($urandom);
		req.idx_a = 10'($urandom);
		req.idx_b = 10'($urandom);
		req.col_a = rgb(16'($urandom), 16'($urandom), 16'($urandom));
		req.col_b = rgb(16'($urandom), 16'($urandom), 16'($urandom));
		return req;
	endfunction

	function automatic lut_request_t index_span_req(input int a, input int b,
	                                                input rgb_t ca, input rgb_t cb);
		lut_request_t req;
		req       = sample_req(REQ_SPAN_INDEX, 24'($urandom));
		req.idx_a = 10'(a);
		req.idx_b = 10'(b);
		req.col_a = ca;
		req.col_b = cb;
		return req;
	endfunction

	function automatic lut_request_t pos_span_req(input logic signed [POS_W-1:0] pa,
	                                              input logic signed [POS_W-1:0] pb,
	                                              input rgb_t ca, input rgb_t cb);
		lut_request_t req;
		req       = sample_req(REQ_SPAN_POS, pa);
		req.pos_b = pb;
		req.col_a = ca;
		req.col_b = cb;
		return req;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			return $urandom_range(1, 3);
		end else if (r < 95) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [COL_W-1:0] rand_channel();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return '0;
		end else if (r == 1) begin
			return '1;
		end
		return 16'($urandom);
	endfunction

	function automatic logic signed [POS_W-1:0] near_unit_pos();
		int v;
		v = int'($urandom_range(0, 32'h11000)) - 32'h800;
		return 24'(v);
	endfunction

	function automatic lut_request_t random_request();
		lut_request_t req;
		int r;
		int shape;
		int lo;
		int hi;
		int pa;
		r     = $urandom_range(0, 99);
		shape = $urandom_range(0, 99);
		req   = sample_req(REQ_SAMPLE_CLAMP, 24'($urandom));
		req.col_a = rgb(rand_channel(), rand_channel(), rand_channel());
		req.col_b = rgb(rand_channel(), rand_channel(), rand_channel());
		if (r < 55) begin
			req.kind = (r < 30) ? REQ_SAMPLE_CLAMP : REQ_SAMPLE_WRAP;
			if (shape < 75) begin
				req.pos_a = near_unit_pos();
			end
		end else if (r < 80) begin
			req.kind = REQ_SPAN_INDEX;
			if (shape < 70) begin
				lo = $urandom_range(0, TABLE_ENTRIES - 1);
				hi = lo + $urandom_range(0, 12);
				if (hi > TABLE_ENTRIES - 1) begin
					hi = TABLE_ENTRIES - 1;
				end
				if ($urandom_range(0, 1) == 0) begin
					req.idx_a = 10'(lo); req.idx_b = 10'(hi);
				end else begin
					req.idx_a = 10'(hi); req.idx_b = 10'(lo);
				end
			end else if (shape < 85) begin
				// around the top edge of the table
				req.idx_a = 10'($urandom_range(TABLE_ENTRIES - 16, TABLE_ENTRIES - 1));
				req.idx_b = 10'($urandom_range(TABLE_ENTRIES - 8, TABLE_ENTRIES + 7));
			end
		end else begin
			req.kind = REQ_SPAN_POS;
			if (shape < 70) begin
				pa = $urandom_range(0, 32'h10000);
				req.pos_a = 24'(pa);
				req.pos_b = 24'(pa + int'($urandom_range(0, 6000)) - 3000);
			end
		end
		return req;
	endfunction

	// ---------------------------------------------------------------- handshake

	task automatic send_request(input lut_request_t req);
		int gap;
		s_axis_tdata  <= {4'b0, req.col_b, req.col_a, req.idx_b, req.idx_a,
		                  req.pos_b, req.pos_a};
		s_axis_tuser  <= req.kind;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		expected_colors.push_back(predict_color_result(req));
		gap = (idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (expected_colors.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
	                               input logic [31:0] want);
		error_count++;
		if (error_count <= MAX_PRINTED) begin
			$display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
		end
	endtask

	initial begin : receiver
		int gap_left;
		gap_left      = 0;
		hold_left     = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				m_axis_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				gap_left = pick_gap() - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : result_check
		color_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_colors.size() == 0) begin
				report_mismatch("unexpected result", m_axis_tdata[31:0], 32'd0);
			end else begin
				want = expected_colors.pop_front();
				if (m_axis_tdata[15:0] !== want.red) begin
					report_mismatch("out_red", 32'(m_axis_tdata[15:0]), 32'(want.red));
				end
				if (m_axis_tdata[31:16] !== want.green) begin
					report_mismatch("out_green", 32'(m_axis_tdata[31:16]), 32'(want.green));
				end
				if (m_axis_tdata[47:32] !== want.blue) begin
					report_mismatch("out_blue", 32'(m_axis_tdata[47:32]), 32'(want.blue));
				end
				if (m_axis_tuser[0] !== want.span_done) begin
					report_mismatch("span_done", 32'(m_axis_tuser[0]), 32'(want.span_done));
				end
				if (m_axis_tuser[1] !== want.span_error) begin
					report_mismatch("span_error", 32'(m_axis_tuser[1]),
					                32'(want.span_error));
				end
			end
		end
	end

	// ---------------------------------------------------------------- tests

	// right after reset every entry reads back as zero
	task automatic test_cleared_table();
		send_request(sample_req(REQ_SAMPLE_CLAMP, 24'h000000));
		send_request(sample_req(REQ_SAMPLE_WRAP, 24'h00_8000));
		send_request(sample_req(REQ_SAMPLE_CLAMP, 24'h7FFFFF));
	endtask

	task automatic test_directed_edges();
		// full ramp first so samples see distinct neighbors
		send_request(index_span_req(0, TABLE_ENTRIES - 1, rgb(16'h0000, 16'hFFFF, 16'h1234),
		                            rgb(16'hFFFF, 16'h0000, 16'hABCD)));
		send_request(sample_req(REQ_SAMPLE_CLAMP, 24'h800000));
		send_request(sample_req(REQ_SAMPLE_CLAMP, 24'h7FFFFF));
		send_request(sample_req(REQ_SAMPLE_CLAMP, 24'h010000));
		send_request(sample_req(REQ_SAMPLE_CLAMP, 24'h00FFFF));
		send_request(sample_req(REQ_SAMPLE_CLAMP, 24'h008000));
		// wrapped negative exact integers map to the top of the table
		send_request(sample_req(REQ_SAMPLE_WRAP, 24'hFF0000));
		send_request(sample_req(REQ_SAMPLE_WRAP, 24'h800000));
		send_request(sample_req(REQ_SAMPLE_WRAP, 24'hFFFFFF));
		send_request(sample_req(REQ_SAMPLE_WRAP, 24'h7FFFFF));
		send_request(sample_req(REQ_SAMPLE_WRAP, 24'h010000));
		// reversed ends, single entry, out of range
		send_request(index_span_req(200, 100, rgb(16'hFFFF, 16'hFFFF, 16'hFFFF),
		                            rgb(16'h0000, 16'h0000, 16'h0000)));
		send_request(index_span_req(50, 50, rgb(16'h8001, 16'h7FFE, 16'hFFFF),
		                            rgb(16'h0000, 16'h1111, 16'h2222)));
		send_request(index_span_req(10, TABLE_ENTRIES, rgb(16'hFFFF, 16'hFFFF, 16'hFFFF),
		                            rgb(16'hFFFF, 16'hFFFF, 16'hFFFF)));
		send_request(index_span_req(1023, 1023, rgb(16'h0000, 16'h0000, 16'h0000),
		                            rgb(16'h0000, 16'h0000, 16'h0000)));
		send_request(index_span_req(1023, 0, rgb(16'h1234, 16'h5678, 16'h9ABC),
		                            rgb(16'hDEF0, 16'h0FED, 16'hCBA9)));
		send_request(pos_span_req(24'h00C000, 24'h004000, rgb(16'hFFFF, 16'h0000, 16'hFFFF),
		                          rgb(16'h0000, 16'hFFFF, 16'h0000)));
		send_request(pos_span_req(24'h800000, 24'h7FFFFF, rgb(16'h0000, 16'h4000, 16'hFFFF),
		                          rgb(16'hFFFF, 16'hC000, 16'h0000)));
		send_request(pos_span_req(24'h010000, 24'h010000, rgb(16'hFFFF, 16'hFFFF, 16'hFFFF),
		                          rgb(16'h0000, 16'h0000, 16'h0000)));
		send_request(index_span_req(TABLE_ENTRIES - 2, TABLE_ENTRIES - 1,
		                            rgb(16'hFFFF, 16'h0000, 16'hFFFF),
		                            rgb(16'h0000, 16'hFFFF, 16'hFFFF)));
		// top of table: upper neighbor saturates
		send_request(sample_req(REQ_SAMPLE_CLAMP, 24'h010000));
		send_request(sample_req(REQ_SAMPLE_CLAMP, 24'h00FF80));
		send_request(sample_req(REQ_SAMPLE_WRAP, 24'h00FF00));
		send_request(index_span_req(0, 0, rgb(16'hFFFF, 16'hFFFF, 16'hFFFF),
		                            rgb(16'h0000, 16'h0000, 16'h0000)));
		send_request(sample_req(REQ_SAMPLE_CLAMP, 24'h000000));
	endtask

	// output held off long enough that the block backs up and stalls its input
	task automatic test_output_stall();
		bit saved_idle;
		drain_results();
		saved_idle   = idle_on;
		idle_on      = 1'b0;
		hold_request = 1'b1;
		for (int i = 0; i < 12; i++) begin
			if (i == 5) begin
				send_request(index_span_req(20, 27, rgb(16'h0100, 16'h0200, 16'h0300),
				                            rgb(16'hF000, 16'hE000, 16'hD000)));
			end else begin
				send_request(sample_req(REQ_SAMPLE_CLAMP, near_unit_pos()));
			end
		end
		idle_on = saved_idle;
	endtask

	task automatic test_random_traffic();
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// every third block of items runs without idling on either side
			if (i % 150 == 0) begin
				idle_on = ((i / 150) % 3) != 2;
			end
			send_request(random_request());
		end
		idle_on = 1'b1;
	endtask

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = REQ_SAMPLE_CLAMP;
		error_count   = 0;
		idle_on       = 1'b1;
		hold_request  = 1'b0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			lut_model[i] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_cleared_table();
		test_directed_edges();
		test_output_stall();
		test_random_traffic();

		drain_results();
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#48_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
